// ----- rtl/core/sparc_fp_branch_load_store_unit_defines.svh -----
// Assertion macros shared by the FP branch / load-store unit RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SPARC_FP_BRANCH_LOAD_STORE_UNIT_DEFINES_SVH
`define SPARC_FP_BRANCH_LOAD_STORE_UNIT_DEFINES_SVH

// explicit clock and active-low reset
`define SFBLS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// default clk_i / rst_ni
`define SFBLS_ASSERT(label, prop, msg) \
  `SFBLS_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/core/sfbls_pkg.sv -----
`timescale 1ns / 1ps
// Types and constants for the FP branch / load-store unit.
// No dependencies.
package sfbls_pkg;

  localparam int unsigned FP_REG_COUNT  = 32;
  localparam int unsigned FP_BANK_DEPTH = FP_REG_COUNT / 2;
  localparam int unsigned FP_BANK_AW    = $clog2(FP_BANK_DEPTH);

  localparam logic [31:0] FSR_RESERVED_MASK = 32'h0030_1000;
  localparam logic [31:0] FSR_VERSION_BITS  = 32'h000E_0000;

  localparam logic [1:0] CLS_BRANCH = 2'd0;
  localparam logic [1:0] CLS_MEM    = 2'd3;

  typedef enum logic [1:0] {
    TRAP_NONE  = 2'd0,
    TRAP_FAULT = 2'd1,
    TRAP_ALIGN = 2'd2,
    TRAP_UNIMP = 2'd3
  } trap_e;

  typedef enum logic [2:0] {
    OP_LDF   = 3'd0,
    OP_LDFSR = 3'd1,
    OP_LDDF  = 3'd3,
    OP_STF   = 3'd4,
    OP_STFSR = 3'd5,
    OP_STDF  = 3'd7
  } op_e;

  localparam logic [1:0] MF_SECOND = 2'd2;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] pc;
    logic [31:0] npc;
    logic [31:0] rs1_value;
    logic [31:0] rs2_value;
    logic        reg_read_fault;
    logic [31:0] load_word_first;
    logic [31:0] load_word_second;
    logic [1:0]  memory_fault;
  } in_t;

  typedef struct packed {
    logic [31:0] new_pc;
    logic [31:0] new_npc;
    trap_e       trap_kind;
    logic [31:0] trap_address;
    logic [31:0] mem_address;
    logic [1:0]  store_count;
    logic [31:0] store_word_first;
    logic [31:0] store_word_second;
  } res_t;

  typedef struct packed {
    logic                  even_we;
    logic                  odd_we;
    logic [FP_BANK_AW-1:0] addr;
    logic [31:0]           even_data;
    logic [31:0]           odd_data;
    logic                  fsr_we;
    logic [31:0]           fsr_data;
  } rf_wr_t;

endpackage

// ----- rtl/core/sfbls_fpregs.sv -----
`timescale 1ns / 1ps
// FP register file as even/odd banks of flops, plus the FSR.
// Depends on sfbls_pkg.
module sfbls_fpregs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             commit_i,
  input  sfbls_pkg::rf_wr_t                wr_i,
  input  logic [sfbls_pkg::FP_BANK_AW-1:0] raddr_i,
  output logic [31:0]                      even_rdata_o,
  output logic [31:0]                      odd_rdata_o,
  output logic [31:0]                      fsr_o
);
  import sfbls_pkg::*;

  logic [31:0] even_q [FP_BANK_DEPTH];
  logic [31:0] odd_q  [FP_BANK_DEPTH];
  logic [31:0] fsr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FP_BANK_DEPTH; i++) begin
        even_q[i] <= '0;
        odd_q[i]  <= '0;
      end
      fsr_q <= '0;
    end else if (commit_i) begin
      if (wr_i.even_we) even_q[wr_i.addr] <= wr_i.even_data;
      if (wr_i.odd_we)  odd_q[wr_i.addr]  <= wr_i.odd_data;
      if (wr_i.fsr_we)  fsr_q             <= wr_i.fsr_data;
    end
  end

  assign even_rdata_o = even_q[raddr_i];
  assign odd_rdata_o  = odd_q[raddr_i];
  assign fsr_o        = fsr_q;

endmodule

// ----- rtl/core/sfbls_exec.sv -----
`timescale 1ns / 1ps
// Execute logic: FBfcc condition/pc update and FP load/store address, checks, data.
// Depends on sfbls_pkg.
module sfbls_exec (
  input  sfbls_pkg::in_t                   item_i,
  input  logic [31:0]                      even_rdata_i,
  input  logic [31:0]                      odd_rdata_i,
  input  logic [31:0]                      fsr_i,
  output logic [sfbls_pkg::FP_BANK_AW-1:0] raddr_o,
  output sfbls_pkg::res_t                  res_o,
  output sfbls_pkg::rf_wr_t                wr_o
);
  import sfbls_pkg::*;

  typedef enum logic [3:0] {
    FC_NEVER = 4'd0,  FC_NE  = 4'd1,  FC_LG  = 4'd2,  FC_UL  = 4'd3,
    FC_L     = 4'd4,  FC_UG  = 4'd5,  FC_G   = 4'd6,  FC_U   = 4'd7,
    FC_ALWAYS = 4'd8, FC_E   = 4'd9,  FC_UE  = 4'd10, FC_GE  = 4'd11,
    FC_UGE   = 4'd12, FC_LE  = 4'd13, FC_ULE = 4'd14, FC_O   = 4'd15
  } fcond_e;

  typedef enum logic [1:0] {
    FCC_E = 2'd0,
    FCC_L = 2'd1,
    FCC_G = 2'd2,
    FCC_U = 2'd3
  } fcc_e;

  function automatic logic cond_holds(fcond_e cond, fcc_e fcc);
    logic e, l, g, u, r;
    e = (fcc == FCC_E);
    l = (fcc == FCC_L);
    g = (fcc == FCC_G);
    u = (fcc == FCC_U);
    unique case (cond)
      FC_NEVER:  r = 1'b0;
      FC_NE:     r = !e;
      FC_LG:     r = l || g;
      FC_UL:     r = u || l;
      FC_L:      r = l;
      FC_UG:     r = u || g;
      FC_G:      r = g;
      FC_U:      r = u;
      FC_ALWAYS: r = 1'b1;
      FC_E:      r = e;
      FC_UE:     r = u || e;
      FC_GE:     r = g || e;
      FC_UGE:    r = !l;
      FC_LE:     r = l || e;
      FC_ULE:    r = !g;
      FC_O:      r = !u;
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

  logic [1:0]  cls;
  logic [4:0]  rd;
  fcond_e      cond;
  logic        annul;
  logic        taken;
  logic [31:0] disp;
  logic [31:0] target;
  logic [31:0] offset;
  logic [31:0] ea;
  logic        misaligned;
  logic        fault0;
  logic        fault1;
  logic [31:0] npc_p4;

  assign cls        = item_i.instruction[31:30];
  assign rd         = item_i.instruction[29:25];
  assign cond       = fcond_e'(rd[3:0]);
  assign annul      = rd[4];
  assign taken      = cond_holds(cond, fcc_e'(fsr_i[11:10]));
  assign disp       = {{8{item_i.instruction[21]}}, item_i.instruction[21:0], 2'b00};
  assign target     = item_i.pc + disp;
  assign offset     = item_i.instruction[13] ?
                      {{19{item_i.instruction[12]}}, item_i.instruction[12:0]} :
                      item_i.rs2_value;
  assign ea         = item_i.rs1_value + offset;
  assign misaligned = (ea[2:0] != 3'b000);
  assign fault0     = item_i.memory_fault[0];
  assign fault1     = (item_i.memory_fault == MF_SECOND);
  assign npc_p4     = item_i.npc + 32'd4;
  assign raddr_o    = rd[4:1];

  always_comb begin
    res_o                   = '0;
    res_o.new_pc            = item_i.pc;
    res_o.new_npc           = item_i.npc;
    res_o.trap_kind         = TRAP_NONE;
    wr_o                    = '0;
    wr_o.addr               = rd[4:1];
    wr_o.even_data          = item_i.load_word_first;
    wr_o.odd_data           = rd[0] ? item_i.load_word_first : item_i.load_word_second;
    wr_o.fsr_data           = item_i.load_word_first;

    if (cls == CLS_BRANCH) begin
      if (taken) begin
        if (annul && cond == FC_ALWAYS) begin
          res_o.new_pc  = target;
          res_o.new_npc = target + 32'd4;
        end else begin
          res_o.new_pc  = item_i.npc;
          res_o.new_npc = target;
        end
      end else if (annul) begin
        res_o.new_pc  = npc_p4;
        res_o.new_npc = item_i.npc + 32'd8;
      end else begin
        res_o.new_pc  = item_i.npc;
        res_o.new_npc = npc_p4;
      end
    end else if (cls == CLS_MEM) begin
      if (item_i.reg_read_fault) begin
        res_o.trap_kind = TRAP_FAULT;
      end else begin
        res_o.mem_address  = ea;
        res_o.trap_address = ea;
        case (item_i.instruction[21:19])
          OP_LDF: begin
            if (fault0) res_o.trap_kind = TRAP_FAULT;
            else begin
              wr_o.even_we = !rd[0];
              wr_o.odd_we  = rd[0];
            end
          end
          OP_LDFSR: begin
            if (fault0) res_o.trap_kind = TRAP_FAULT;
            else wr_o.fsr_we = 1'b1;
          end
          OP_LDDF: begin
            if (misaligned) res_o.trap_kind = TRAP_ALIGN;
            else if (fault0) res_o.trap_kind = TRAP_FAULT;
            else begin
              wr_o.even_we   = 1'b1;
              wr_o.odd_data  = item_i.load_word_second;
              if (fault1) res_o.trap_kind = TRAP_FAULT;
              else wr_o.odd_we = 1'b1;
            end
          end
          OP_STF: begin
            if (fault0) res_o.trap_kind = TRAP_FAULT;
            else begin
              res_o.store_word_first = rd[0] ? odd_rdata_i : even_rdata_i;
              res_o.store_count      = 2'd1;
            end
          end
          OP_STFSR: begin
            if (fault0) res_o.trap_kind = TRAP_FAULT;
            else begin
              res_o.store_word_first = (fsr_i & ~FSR_RESERVED_MASK) | FSR_VERSION_BITS;
              res_o.store_count      = 2'd1;
            end
          end
          OP_STDF: begin
            if (misaligned) res_o.trap_kind = TRAP_ALIGN;
            else if (fault0) res_o.trap_kind = TRAP_FAULT;
            else begin
              res_o.store_word_first = even_rdata_i;
              res_o.store_count      = 2'd1;
              if (fault1) res_o.trap_kind = TRAP_FAULT;
              else begin
                res_o.store_word_second = odd_rdata_i;
                res_o.store_count       = 2'd2;
              end
            end
          end
          default: begin
            res_o.trap_kind    = TRAP_UNIMP;
            res_o.trap_address = item_i.pc;
          end
        endcase
        if (res_o.trap_kind == TRAP_NONE) begin
          res_o.new_pc  = item_i.npc;
          res_o.new_npc = npc_p4;
        end
      end
    end else begin
      res_o.trap_kind    = TRAP_UNIMP;
      res_o.trap_address = item_i.pc;
    end

    if (res_o.trap_kind == TRAP_NONE) res_o.trap_address = '0;
  end

endmodule

// ----- rtl/core/sparc_fp_branch_load_store_unit.sv -----
`timescale 1ns / 1ps
// Channel | Handshake               | Payload
// in      | in_valid_i / in_ready_o | instruction, pc, npc, rs1/rs2 values, faults, load words
// out     | out_valid_o/out_ready_i | new_pc, new_npc, trap_kind/address, mem_address, stores
// One beat per cycle while the output is not held; each beat is registered in the input reg, then in the result reg.
// FP register file and FSR are read and updated in the execute cycle, as the result reg loads.
// A held result stalls execute; the input reg still takes a beat while execute is empty.
// Reset clears the FP register file, the FSR and all valid flags.
// Top level; depends on sfbls_pkg, sfbls_fpregs, sfbls_exec and the defines header.
`include "sparc_fp_branch_load_store_unit_defines.svh"
module sparc_fp_branch_load_store_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instruction_i,
  input  logic [31:0] pc_i,
  input  logic [31:0] npc_i,
  input  logic [31:0] rs1_value_i,
  input  logic [31:0] rs2_value_i,
  input  logic        reg_read_fault_i,
  input  logic [31:0] load_word_first_i,
  input  logic [31:0] load_word_second_i,
  input  logic [1:0]  memory_fault_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] new_pc_o,
  output logic [31:0] new_npc_o,
  output logic [1:0]  trap_kind_o,
  output logic [31:0] trap_address_o,
  output logic [31:0] mem_address_o,
  output logic [1:0]  store_count_o,
  output logic [31:0] store_word_first_o,
  output logic [31:0] store_word_second_o
);
  import sfbls_pkg::*;

  in_t                   item_q;
  logic                  item_valid_q, item_valid_d;
  res_t                  res_d, res_q;
  logic                  out_valid_q, out_valid_d;
  logic                  advance;
  logic                  in_fire;
  rf_wr_t                rf_wr;
  logic [FP_BANK_AW-1:0] rf_raddr;
  logic [31:0]           even_rdata;
  logic [31:0]           odd_rdata;
  logic [31:0]           fsr;

  assign advance      = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o   = !item_valid_q || advance;
  assign in_fire      = in_valid_i && in_ready_o;
  assign item_valid_d = in_fire || (item_valid_q && !advance);
  assign out_valid_d  = advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= '{instruction:      instruction_i,
                  pc:               pc_i,
                  npc:              npc_i,
                  rs1_value:        rs1_value_i,
                  rs2_value:        rs2_value_i,
                  reg_read_fault:   reg_read_fault_i,
                  load_word_first:  load_word_first_i,
                  load_word_second: load_word_second_i,
                  memory_fault:     memory_fault_i};
    end
    if (advance) res_q <= res_d;
  end

  sfbls_fpregs u_fpregs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .commit_i     (advance),
    .wr_i         (rf_wr),
    .raddr_i      (rf_raddr),
    .even_rdata_o (even_rdata),
    .odd_rdata_o  (odd_rdata),
    .fsr_o        (fsr)
  );

  sfbls_exec u_exec (
    .item_i       (item_q),
    .even_rdata_i (even_rdata),
    .odd_rdata_i  (odd_rdata),
    .fsr_i        (fsr),
    .raddr_o      (rf_raddr),
    .res_o        (res_d),
    .wr_o         (rf_wr)
  );

  assign out_valid_o         = out_valid_q;
  assign new_pc_o            = res_q.new_pc;
  assign new_npc_o           = res_q.new_npc;
  assign trap_kind_o         = res_q.trap_kind;
  assign trap_address_o      = res_q.trap_address;
  assign mem_address_o       = res_q.mem_address;
  assign store_count_o       = res_q.store_count;
  assign store_word_first_o  = res_q.store_word_first;
  assign store_word_second_o = res_q.store_word_second;

  `SFBLS_ASSERT(a_adv_gives_out, advance |=> out_valid_q, "execute beat lost on its way out")
  `SFBLS_ASSERT(a_two_stores_no_trap, out_valid_q && res_q.store_count == 2'd2 |-> res_q.trap_kind == TRAP_NONE, "two stores reported with a trap")
  `SFBLS_ASSERT(a_align_no_store, out_valid_q && res_q.trap_kind == TRAP_ALIGN |-> res_q.store_count == 2'd0 && res_q.mem_address[2:0] != 3'b000, "alignment trap inconsistent")
  `SFBLS_ASSERT(a_no_trap_addr, out_valid_q && res_q.trap_kind == TRAP_NONE |-> res_q.trap_address == 32'd0, "trap address set without trap")

endmodule

// ----- verif/sparc_fp_branch_load_store_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sparc_fp_branch_load_store_unit: directed table, then random beats,
// each result checked against its row's fixed outcome or a model of FP regs, FSR, pc/npc.
// Depends on sfbls_pkg and the unit RTL.
module sparc_fp_branch_load_store_unit_tb;
  import sfbls_pkg::*;

  typedef enum logic [3:0] {
    FBN, FBNE, FBLG, FBUL, FBL, FBUG, FBG, FBU,
    FBA, FBE, FBUE, FBGE, FBUGE, FBLE, FBULE, FBO
  } fbcc_e;

  typedef enum logic [1:0] {FCC_E, FCC_L, FCC_G, FCC_U} fcc_e;

  localparam logic [2:0] OP_UNIMP_A = 3'd2;
  localparam logic [2:0] OP_UNIMP_B = 3'd6;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         RANDOM_BEATS = 800;

  typedef struct {
    in_t  beat;
    bit   typed;
    res_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] instruction_i = '0;
  logic [31:0] pc_i = '0;
  logic [31:0] npc_i = '0;
  logic [31:0] rs1_value_i = '0;
  logic [31:0] rs2_value_i = '0;
  logic        reg_read_fault_i = 1'b0;
  logic [31:0] load_word_first_i = '0;
  logic [31:0] load_word_second_i = '0;
  logic [1:0]  memory_fault_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] new_pc_o;
  logic [31:0] new_npc_o;
  logic [1:0]  trap_kind_o;
  logic [31:0] trap_address_o;
  logic [31:0] mem_address_o;
  logic [1:0]  store_count_o;
  logic [31:0] store_word_first_o;
  logic [31:0] store_word_second_o;

  logic [31:0] fp_regs [FP_REG_COUNT];
  logic [31:0] fsr;
  res_t        pending_outcomes [$];
  stim_row_t   directed_rows [$];
  res_t        head_outcome;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          in_idle_pct = 21;
  int          out_idle_pct = 21;

  sparc_fp_branch_load_store_unit dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic fcc_matches(fbcc_e cond, logic [1:0] fcc);
    logic e, l, g, u;
    e = (fcc == FCC_E);
    l = (fcc == FCC_L);
    g = (fcc == FCC_G);
    u = (fcc == FCC_U);
    case (cond)
      FBN:     return 1'b0;
      FBNE:    return !e;
      FBLG:    return l || g;
      FBUL:    return u || l;
      FBL:     return l;
      FBUG:    return u || g;
      FBG:     return g;
      FBU:     return u;
      FBA:     return 1'b1;
      FBE:     return e;
      FBUE:    return u || e;
      FBGE:    return g || e;
      FBUGE:   return !l;
      FBLE:    return l || e;
      FBULE:   return !g;
      default: return !u;
    endcase
  endfunction

  // Updates fp_regs / fsr as the unit would and returns the outcome of one beat.
  function automatic res_t execute_fp_op(in_t x);
    res_t        r;
    logic [31:0] disp, target, off, ea;
    logic [4:0]  rd;
    fbcc_e       cond;
    logic        f0, f1;
    r = '0;
    r.new_pc = x.pc;
    r.new_npc = x.npc;
    r.trap_kind = TRAP_NONE;
    rd = x.instruction[29:25];
    f0 = x.memory_fault[0];
    f1 = (x.memory_fault == MF_SECOND);
    if (x.instruction[31:30] == CLS_BRANCH) begin
      cond = fbcc_e'(rd[3:0]);
      disp = {{8{x.instruction[21]}}, x.instruction[21:0], 2'b00};
      target = x.pc + disp;
      if (fcc_matches(cond, fsr[11:10])) begin
        if (rd[4] && cond == FBA) begin
          r.new_pc = target;
          r.new_npc = target + 32'd4;
        end else begin
          r.new_pc = x.npc;
          r.new_npc = target;
        end
      end else if (rd[4]) begin
        r.new_pc = x.npc + 32'd4;
        r.new_npc = x.npc + 32'd8;
      end else begin
        r.new_pc = x.npc;
        r.new_npc = x.npc + 32'd4;
      end
    end else if (x.instruction[31:30] == CLS_MEM) begin
      if (x.reg_read_fault) begin
        r.trap_kind = TRAP_FAULT;
      end else begin
        off = x.instruction[13] ? {{19{x.instruction[12]}}, x.instruction[12:0]} : x.rs2_value;
        ea = x.rs1_value + off;
        r.mem_address = ea;
        r.trap_address = ea;
        case (x.instruction[21:19])
          OP_LDF: begin
            if (f0) r.trap_kind = TRAP_FAULT;
            else fp_regs[rd] = x.load_word_first;
          end
          OP_LDFSR: begin
            if (f0) r.trap_kind = TRAP_FAULT;
            else fsr = x.load_word_first;
          end
          OP_LDDF: begin
            if (ea[2:0] != 3'd0) r.trap_kind = TRAP_ALIGN;
            else if (f0) r.trap_kind = TRAP_FAULT;
            else begin
              fp_regs[{rd[4:1], 1'b0}] = x.load_word_first;
              if (f1) r.trap_kind = TRAP_FAULT;
              else fp_regs[{rd[4:1], 1'b1}] = x.load_word_second;
            end
          end
          OP_STF: begin
            if (f0) r.trap_kind = TRAP_FAULT;
            else begin
              r.store_word_first = fp_regs[rd];
              r.store_count = 2'd1;
            end
          end
          OP_STFSR: begin
            if (f0) r.trap_kind = TRAP_FAULT;
            else begin
              r.store_word_first = (fsr & ~FSR_RESERVED_MASK) | FSR_VERSION_BITS;
              r.store_count = 2'd1;
            end
          end
          OP_STDF: begin
            if (ea[2:0] != 3'd0) r.trap_kind = TRAP_ALIGN;
            else if (f0) r.trap_kind = TRAP_FAULT;
            else begin
              r.store_word_first = fp_regs[{rd[4:1], 1'b0}];
              r.store_count = 2'd1;
              if (f1) r.trap_kind = TRAP_FAULT;
              else begin
                r.store_word_second = fp_regs[{rd[4:1], 1'b1}];
                r.store_count = 2'd2;
              end
            end
          end
          default: begin
            r.trap_kind = TRAP_UNIMP;
            r.trap_address = x.pc;
          end
        endcase
        if (r.trap_kind == TRAP_NONE) begin
          r.new_pc = x.npc;
          r.new_npc = x.npc + 32'd4;
        end
      end
    end else begin
      r.trap_kind = TRAP_UNIMP;
      r.trap_address = x.pc;
    end
    if (r.trap_kind == TRAP_NONE) r.trap_address = '0;
    return r;
  endfunction

  function automatic logic [31:0] fb_word(bit annul, fbcc_e cond, logic [21:0] disp22);
    return {CLS_BRANCH, annul, cond, 3'b110, disp22};
  endfunction

  function automatic logic [31:0] ls_word(logic [2:0] op, logic [4:0] rd, bit imm,
                                          logic [12:0] low);
    return {CLS_MEM, rd, 3'b100, op, 5'd0, imm, low};
  endfunction

  function automatic in_t beat(logic [31:0] inst, logic [31:0] pc, logic [31:0] npc,
                               logic [31:0] rs1, logic [31:0] rs2, logic rf,
                               logic [31:0] ld0, logic [31:0] ld1, logic [1:0] mf);
    in_t x;
    x.instruction = inst;
    x.pc = pc;
    x.npc = npc;
    x.rs1_value = rs1;
    x.rs2_value = rs2;
    x.reg_read_fault = rf;
    x.load_word_first = ld0;
    x.load_word_second = ld1;
    x.memory_fault = mf;
    return x;
  endfunction

  function automatic res_t outcome(logic [31:0] pc, logic [31:0] npc, trap_e t,
                                   logic [31:0] taddr, logic [31:0] maddr);
    res_t r;
    r = '0;
    r.new_pc = pc;
    r.new_npc = npc;
    r.trap_kind = t;
    r.trap_address = taddr;
    r.mem_address = maddr;
    return r;
  endfunction

  task automatic add_row(in_t b, bit typed, res_t w);
    stim_row_t row;
    row.beat = b;
    row.typed = typed;
    row.want = w;
    directed_rows.push_back(row);
  endtask

  function automatic in_t random_beat();
    in_t         x;
    int          kind;
    int          mfsel;
    logic [2:0]  op;
    logic        imm;
    logic [12:0] low;
    kind = $urandom_range(99);
    mfsel = $urandom_range(9);
    x = beat($urandom, $urandom, $urandom, $urandom, $urandom, ($urandom_range(19) == 0),
             $urandom, $urandom, 2'd0);
    x.memory_fault = (mfsel < 7) ? 2'd0 : 2'(mfsel - 6);
    if (kind < 30) begin
      x.instruction = fb_word(1'($urandom_range(1)), fbcc_e'($urandom_range(15)),
                              22'($urandom));
      x.instruction[24:22] = 3'($urandom);
    end else if (kind < 88) begin
      op = 3'($urandom_range(7));
      if ((op == OP_UNIMP_A || op == OP_UNIMP_B) && $urandom_range(2) != 0) op = OP_LDFSR;
      imm = 1'($urandom_range(1));
      low = 13'($urandom);
      if ($urandom_range(3) != 0) begin
        x.rs1_value[2:0] = 3'd0;
        x.rs2_value[2:0] = 3'd0;
        low[2:0] = 3'd0;
      end
      x.instruction = ls_word(op, 5'($urandom), imm, low);
      x.instruction[24:22] = 3'($urandom);
      x.instruction[18:14] = 5'($urandom);
    end else begin
      x.instruction = $urandom;
    end
    return x;
  endfunction

  task automatic send_beat(in_t x);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i <= 1'b1;
    instruction_i <= x.instruction;
    pc_i <= x.pc;
    npc_i <= x.npc;
    rs1_value_i <= x.rs1_value;
    rs2_value_i <= x.rs2_value;
    reg_read_fault_i <= x.reg_read_fault;
    load_word_first_i <= x.load_word_first;
    load_word_second_i <= x.load_word_second;
    memory_fault_i <= x.memory_fault;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %h actual %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t ns: beat with none expected, actual new_pc %h", $time, new_pc_o);
        mismatch_count++;
      end else begin
        head_outcome = pending_outcomes.pop_front();
        compare_field("new_pc", head_outcome.new_pc, new_pc_o);
        compare_field("new_npc", head_outcome.new_npc, new_npc_o);
        compare_field("trap_kind", 32'(head_outcome.trap_kind), 32'(trap_kind_o));
        compare_field("trap_address", head_outcome.trap_address, trap_address_o);
        compare_field("mem_address", head_outcome.mem_address, mem_address_o);
        compare_field("store_count", 32'(head_outcome.store_count), 32'(store_count_o));
        compare_field("store_word_first", head_outcome.store_word_first, store_word_first_o);
        compare_field("store_word_second", head_outcome.store_word_second,
                      store_word_second_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    res_t predicted;
    in_t  x;
    foreach (fp_regs[i]) fp_regs[i] = '0;
    fsr = '0;

    add_row(beat(fb_word(0, FBN, 22'h10), 32'h1000, 32'h1004, 0, 0, 0, 0, 0, 0), 1,
            outcome(32'h1004, 32'h1008, TRAP_NONE, 0, 0));
    add_row(beat(fb_word(1, FBN, 22'h10), 32'h1000, 32'h1004, 0, 0, 0, 0, 0, 0), 1,
            outcome(32'h1008, 32'h100C, TRAP_NONE, 0, 0));
    // fba,a jumps straight to the target
    add_row(beat(fb_word(1, FBA, 22'h1FFFFF), 32'h1000, 32'h1004, 0, 0, 0, 0, 0, 0), 1,
            outcome(32'h0080_0FFC, 32'h0080_1000, TRAP_NONE, 0, 0));
    add_row(beat(fb_word(0, FBA, 22'h200000), 32'h1000, 32'h1004, 0, 0, 0, 0, 0, 0), 1,
            outcome(32'h1004, 32'hFF80_1000, TRAP_NONE, 0, 0));
    add_row(beat(fb_word(0, FBE, 22'h3FFFFF), 32'hFFFF_FFFC, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(beat(fb_word(1, FBNE, 22'h5), 0, 32'hFFFF_FFFC, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(beat(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 0, 0, 0, 0, 0, 0), 1,
            outcome(32'hFFFF_FFFF, 32'h1234_5678, TRAP_UNIMP, 32'hFFFF_FFFF, 0));
    add_row(beat(32'h8000_0000, 0, 4, 0, 0, 0, 0, 0, 0), 1,
            outcome(0, 4, TRAP_UNIMP, 0, 0));
    add_row(beat(ls_word(OP_LDF, 3, 1, 13'h10), 32'h2000, 32'h2004, 32'h100, 0, 1, 0, 0, 0),
            1, outcome(32'h2000, 32'h2004, TRAP_FAULT, 0, 0));
    add_row(beat(ls_word(OP_LDF, 3, 1, 13'h10), 32'h2000, 32'h2004, 32'h100, 0, 0, 0, 0, 1),
            1, outcome(32'h2000, 32'h2004, TRAP_FAULT, 32'h110, 32'h110));
    add_row(beat(ls_word(OP_LDF, 3, 1, 13'h10), 32'h2000, 32'h2004, 32'h100, 0, 0, 0, 0, 3),
            1, outcome(32'h2000, 32'h2004, TRAP_FAULT, 32'h110, 32'h110));
    add_row(beat(ls_word(OP_LDF, 3, 1, 13'h10), 32'h2000, 32'h2004, 32'h100, 0, 0,
                 32'hDEAD_BEEF, 0, 2), 0, '0);
    add_row(beat(ls_word(OP_LDDF, 5, 1, 13'h4), 32'h2000, 32'h2004, 32'h100, 0, 0, 0, 0, 0),
            1, outcome(32'h2000, 32'h2004, TRAP_ALIGN, 32'h104, 32'h104));
    add_row(beat(ls_word(OP_STDF, 5, 0, 13'h0), 32'h2000, 32'h2004, 32'h100, 3, 0, 0, 0, 0),
            1, outcome(32'h2000, 32'h2004, TRAP_ALIGN, 32'h103, 32'h103));
    add_row(beat(ls_word(OP_LDDF, 5, 1, 13'h8), 32'h2000, 32'h2004, 32'h100, 0, 0,
                 32'hA5A5_A5A5, 32'h5A5A_5A5A, 2), 0, '0);
    add_row(beat(ls_word(OP_LDDF, 7, 1, 13'h0), 32'h2000, 32'h2004, 0, 0, 0,
                 32'hFFFF_FFFF, 0, 0), 0, '0);
    add_row(beat(ls_word(OP_STDF, 5, 1, 13'h1FF8), 32'h2000, 32'h2004, 32'h108, 0, 0, 0, 0, 2),
            0, '0);
    add_row(beat(ls_word(OP_STDF, 6, 0, 13'h0), 32'h2000, 32'h2004, 32'hFFFF_FFF8, 32'h10, 0,
                 0, 0, 0), 0, '0);
    add_row(beat(ls_word(OP_STF, 3, 1, 13'h0), 32'h2000, 32'h2004, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(beat(ls_word(OP_LDFSR, 0, 1, 13'h0), 32'h2000, 32'h2004, 0, 0, 0,
                 32'hFFFF_FFFF, 0, 0), 0, '0);
    add_row(beat(ls_word(OP_STFSR, 0, 1, 13'h0), 32'h2000, 32'h2004, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(beat(fb_word(0, FBU, 22'h1), 32'h2000, 32'h2004, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(beat(ls_word(OP_UNIMP_A, 0, 1, 13'h1FF8), 32'h3000, 32'h3004, 32'h40, 0, 0,
                 0, 0, 0), 1, outcome(32'h3000, 32'h3004, TRAP_UNIMP, 32'h3000, 32'h38));
    add_row(beat(ls_word(OP_UNIMP_B, 31, 0, 13'h0), 32'h3000, 32'h3004, 32'h1234_0000,
                 32'h0000_5678, 0, 0, 0, 0), 0, '0);
    add_row(beat(32'hFFFF_FFFF, 32'h4000, 32'h4004, 0, 0, 0, 0, 0, 0), 0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].beat);
      predicted = execute_fp_op(directed_rows[i].beat);
      pending_outcomes.push_back(directed_rows[i].typed ? directed_rows[i].want : predicted);
    end

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      in_idle_pct = (n >= 300 && n < 450) ? 0 : 21;
      out_idle_pct = in_idle_pct;
      x = random_beat();
      send_beat(x);
      pending_outcomes.push_back(execute_fp_op(x));
    end
    in_valid_i <= 1'b0;
    out_idle_pct = 21;

    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sparc_fp_branch_load_store_unit.f -----
+incdir+rtl/core
rtl/core/sfbls_pkg.sv
rtl/core/sfbls_fpregs.sv
rtl/core/sfbls_exec.sv
rtl/core/sparc_fp_branch_load_store_unit.sv
verif/sparc_fp_branch_load_store_unit_tb.sv
